// File: rtl/assert_macros.svh
// Assertion helpers for the envelope generator RTL.
// ASSERT_CLK expects signals named clk and rst, ASSERT_ALL one named clk, in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every clock edge, reset included
`define ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALL(lbl, prop, msg)
`endif
`endif

// File: rtl/adsr_pkg.sv
package adsr_pkg;

  // Field widths
  localparam int LEVEL_W    = 24;
  localparam int ALPHA_W    = 24;
  localparam int OFFSET_W   = 25;
  localparam int Q_FRAC     = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  // Default samples per frame
  localparam int FRAME_LEN_DEF = 32;

  // 1.0 in Q1.23
  localparam logic [LEVEL_W-1:0] Q23_ONE = 24'h800000;

  // Register reset values
  localparam logic [ALPHA_W-1:0]         ATTACK_ALPHA_RST   = '0;
  localparam logic signed [OFFSET_W-1:0] ATTACK_OFFSET_RST  = 25'sh0800000;
  localparam logic [ALPHA_W-1:0]         DECAY_ALPHA_RST    = '0;
  localparam logic signed [OFFSET_W-1:0] DECAY_OFFSET_RST   = 25'sh0400000;
  localparam logic [ALPHA_W-1:0]         RELEASE_ALPHA_RST  = '0;
  localparam logic signed [OFFSET_W-1:0] RELEASE_OFFSET_RST = '0;
  localparam logic [LEVEL_W-1:0]         SUSTAIN_LEVEL_RST  = 24'h400000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK_ALPHA   = 3'd0,
    REG_ATTACK_OFFSET  = 3'd1,
    REG_DECAY_ALPHA    = 3'd2,
    REG_DECAY_OFFSET   = 3'd3,
    REG_RELEASE_ALPHA  = 3'd4,
    REG_RELEASE_OFFSET = 3'd5,
    REG_SUSTAIN_LEVEL  = 3'd6
  } cfg_reg_t;

  // Envelope phase, one-hot
  typedef enum logic [4:0] {
    PH_OFF     = 5'b00001,
    PH_ATTACK  = 5'b00010,
    PH_DECAY   = 5'b00100,
    PH_SUSTAIN = 5'b01000,
    PH_RELEASE = 5'b10000
  } phase_t;

  // Frame sequencer state, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

endpackage

// File: rtl/adsr_envelope_generator.sv
// ADSR envelope generator, exponential one-pole segments, Q1.23.
// Input channel (in_valid/in_ready): one frame tick with gate_on and trigger.
// On each transfer the phase machine (off, attack, decay, sustain, release)
// is stepped once and the phase's coefficient pair is loaded.
// Output channel (out_valid/out_ready): FRAME_LEN samples per tick, the
// last one flagged by last_of_frame. Off phase gives zero samples.
// After an input transfer the sequencer enters its run state and then
// loads the first sample into the output register. Throughput: one
// sample per cycle while the receiver does not stall, from the single
// multiply-add-clamp unit, which runs once per sample on the running level.
// Each run ends in the idle state, where the next tick is taken.
// in_ready is high only between runs; the next tick may be taken while the
// final sample of the previous run still sits in the output register.
// A receiver stall freezes the run: the output register holds its sample
// and the sample unit waits. Configuration writes (cfg_we) take effect
// at once; the user must issue them only between runs (not enforced).
// Synchronous reset clears the phase to off, the level to zero and loads
// the register defaults.
`include "assert_macros.svh"

module adsr_envelope_generator #(
  parameter int FRAME_LEN = adsr_pkg::FRAME_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [adsr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              gate_on,
  input  logic                              trigger,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [adsr_pkg::LEVEL_W-1:0]      level,
  output logic                              last_of_frame
);
  import adsr_pkg::*;

  localparam int CNT_W = $clog2(FRAME_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_LEN - 1);

  // Configuration registers
  logic [ALPHA_W-1:0]         attack_alpha, decay_alpha, release_alpha;
  logic signed [OFFSET_W-1:0] attack_offset, decay_offset, release_offset;
  logic [LEVEL_W-1:0]         sustain_level;

  // Envelope state
  phase_t                     phase, phase_next;
  logic [LEVEL_W-1:0]         env_level, env_level_next;
  logic [ALPHA_W-1:0]         cur_alpha, cur_alpha_next;
  logic signed [OFFSET_W-1:0] cur_offset, cur_offset_next;

  // Sequencer
  seq_state_t         state;
  logic [CNT_W-1:0]   cnt;
  logic               in_xfer;
  logic               smp_load;
  logic               smp_last;
  logic [LEVEL_W-1:0] mac_level;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign smp_load = (state == ST_RUN) && (!out_valid || out_ready);
  assign smp_last = (cnt == CNT_LAST);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_alpha   <= ATTACK_ALPHA_RST;
      attack_offset  <= ATTACK_OFFSET_RST;
      decay_alpha    <= DECAY_ALPHA_RST;
      decay_offset   <= DECAY_OFFSET_RST;
      release_alpha  <= RELEASE_ALPHA_RST;
      release_offset <= RELEASE_OFFSET_RST;
      sustain_level  <= SUSTAIN_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ATTACK_ALPHA:   attack_alpha   <= cfg_data[ALPHA_W-1:0];
        REG_ATTACK_OFFSET:  attack_offset  <= $signed(cfg_data[OFFSET_W-1:0]);
        REG_DECAY_ALPHA:    decay_alpha    <= cfg_data[ALPHA_W-1:0];
        REG_DECAY_OFFSET:   decay_offset   <= $signed(cfg_data[OFFSET_W-1:0]);
        REG_RELEASE_ALPHA:  release_alpha  <= cfg_data[ALPHA_W-1:0];
        REG_RELEASE_OFFSET: release_offset <= $signed(cfg_data[OFFSET_W-1:0]);
        REG_SUSTAIN_LEVEL:  sustain_level  <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Phase rules, first match wins
  always_comb begin
    phase_next      = phase;
    env_level_next  = env_level;
    cur_alpha_next  = cur_alpha;
    cur_offset_next = cur_offset;
    if (!gate_on && phase == PH_RELEASE && env_level == '0) begin
      phase_next      = PH_OFF;
      env_level_next  = '0;
      cur_alpha_next  = '0;
      cur_offset_next = '0;
    end else if (!gate_on && phase != PH_OFF) begin
      phase_next      = PH_RELEASE;
      cur_alpha_next  = release_alpha;
      cur_offset_next = release_offset;
    end else if (trigger) begin
      phase_next      = PH_ATTACK;
      cur_alpha_next  = attack_alpha;
      cur_offset_next = attack_offset;
    end else if (phase == PH_ATTACK && env_level >= Q23_ONE) begin
      phase_next      = PH_DECAY;
      cur_alpha_next  = decay_alpha;
      cur_offset_next = decay_offset;
    end else if (phase == PH_DECAY && env_level <= sustain_level) begin
      phase_next      = PH_SUSTAIN;
      cur_alpha_next  = Q23_ONE;
      cur_offset_next = '0;
      env_level_next  = (sustain_level > Q23_ONE) ? Q23_ONE : sustain_level;
    end
  end

  // Shared multiply-add-clamp unit
  adsr_mac u_mac (
    .y      (env_level),
    .alpha  (cur_alpha),
    .offset (cur_offset),
    .y_next (mac_level)
  );

  // Envelope state: phase step on a tick, level step on each sample
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_OFF;
      env_level  <= '0;
      cur_alpha  <= '0;
      cur_offset <= '0;
    end else if (in_xfer) begin
      phase      <= phase_next;
      env_level  <= env_level_next;
      cur_alpha  <= cur_alpha_next;
      cur_offset <= cur_offset_next;
    end else if (smp_load && phase != PH_OFF) begin
      env_level <= mac_level;
    end
  end

  // Frame sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            state <= ST_RUN;
            cnt   <= '0;
          end
        end
        ST_RUN: begin
          if (smp_load) begin
            if (smp_last) begin
              state <= ST_IDLE;
              cnt   <= '0;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
          cnt   <= '0;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (smp_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_load) begin
      level         <= (phase == PH_OFF) ? '0 : mac_level;
      last_of_frame <= smp_last;
    end
  end

  // Checks
  `ASSERT_CLK(a_level_range, out_valid |-> level <= Q23_ONE, "level above 1.0")
  `ASSERT_CLK(a_tick_at_frame_start, in_xfer |-> cnt == '0, "tick taken mid-run")
  `ASSERT_CLK(a_run_end_marked, (smp_load && smp_last) |=>
    (state == ST_IDLE && out_valid && last_of_frame), "run end not marked")
  `ASSERT_ALL(a_sustain_pair, phase == PH_SUSTAIN |->
    (cur_alpha == Q23_ONE && cur_offset == '0), "sustain coefficients wrong")

endmodule

// File: rtl/adsr_mac.sv
module adsr_mac (
  input  logic [adsr_pkg::LEVEL_W-1:0]         y,
  input  logic [adsr_pkg::ALPHA_W-1:0]         alpha,
  input  logic signed [adsr_pkg::OFFSET_W-1:0] offset,
  output logic [adsr_pkg::LEVEL_W-1:0]         y_next
);
  import adsr_pkg::*;

  localparam int PROD_W  = LEVEL_W + ALPHA_W;
  localparam int SCALE_W = PROD_W - Q_FRAC;
  localparam int SUM_W   = OFFSET_W + 2;

  logic [PROD_W-1:0]       prod;
  logic [SCALE_W-1:0]      scaled;
  logic signed [SUM_W-1:0] sum;

  // One-pole step: offset + floor(y * alpha / 2^23)
  assign prod   = PROD_W'(y) * PROD_W'(alpha);
  assign scaled = prod[PROD_W-1:Q_FRAC];
  assign sum    = $signed({{2{offset[OFFSET_W-1]}}, offset})
                + $signed({{(SUM_W-SCALE_W){1'b0}}, scaled});

  // Clamp to 0 .. 1.0
  always_comb begin
    if (sum[SUM_W-1]) begin
      y_next = '0;
    end else if (sum > $signed(SUM_W'(Q23_ONE))) begin
      y_next = Q23_ONE;
    end else begin
      y_next = sum[LEVEL_W-1:0];
    end
  end

endmodule
